@@ hw/rtl/bfl_pkg.sv @@
`default_nettype none

package bfl_pkg;

    typedef logic [2:0] t_phase;

    // parser phases
    localparam t_phase PH_HDR  = 3'd0;
    localparam t_phase PH_TYPE = 3'd1;
    localparam t_phase PH_KEY  = 3'd2;
    localparam t_phase PH_SLEN = 3'd3;
    localparam t_phase PH_VAL  = 3'd4;
    localparam t_phase PH_DONE = 3'd5;

    typedef logic [1:0] t_status;

    localparam t_status ST_FOUND    = 2'd0;
    localparam t_status ST_END      = 2'd1;
    localparam t_status ST_BAD_TYPE = 2'd2;
    localparam t_status ST_OVERSIZE = 2'd3;

    // BSON element types with a known value size, plus the highest accepted type byte
    localparam logic [7:0] BT_DOUBLE = 8'h01;
    localparam logic [7:0] BT_STRING = 8'h02;
    localparam logic [7:0] BT_BOOL   = 8'h08;
    localparam logic [7:0] BT_INT32  = 8'h10;
    localparam logic [7:0] BT_INT64  = 8'h12;
    localparam logic [7:0] BT_MAX    = 8'h7E;

endpackage

`default_nettype wire

@@ hw/rtl/bfl_ram.sv @@
`default_nettype none

module bfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                       i_wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                       o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // read-first: a same-cycle write shows up on the next read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ hw/rtl/bson_field_locator.sv @@
`default_nettype none

// BSON field locator. Load a query key one word at a time with i_kind = 0
// (a zero byte ends the key, i_last closes it; the next key word starts a
// fresh key), then stream a BSON document one byte per word with i_kind = 1
// and i_last on its final byte. The block walks the elements (type byte,
// zero-ended key, value skipped by type: string, int32, int64, boolean,
// double) and returns exactly one result word per document: status (found,
// end without match, invalid type, oversize document), plus the matched
// element's type byte, the offset of its type byte and its total length.
// Keys longer than KEY_MAX bytes never match; a declared document length
// above DOC_MAX reports oversize after the fourth byte. One word is taken
// every clock cycle, query or document alike, with no gaps: each word
// updates the parser registers as it is taken, and the result appears
// on the output register in the cycle after the word that decides it. The
// input stalls only while a result word is held and i_ready is low
// (o_ready = !o_valid | i_ready); a result taken in the same cycle as a new
// word frees the register for that word's result.
// Key bytes sit in a small RAM; its read port is aimed one word ahead at
// the next key position, with a bypass for a key byte written the cycle
// before. No clearing pass after reset.
module bson_field_locator #(
    parameter int DOC_MAX = 256,
    parameter int KEY_MAX = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic       i_kind,
    input  wire logic [7:0] i_data_byte,
    input  wire logic       i_last,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_status,
    output logic [7:0]      o_element_type,
    output logic [7:0]      o_element_offset,
    output logic [8:0]      o_element_length
);

    import bfl_pkg::*;

    localparam int PW  = $clog2(DOC_MAX + 1);              // byte position
    localparam int KW  = $clog2(KEY_MAX + 1);              // query length
    localparam int KPW = $clog2(KEY_MAX + 2);              // key position
    localparam int AW  = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    // query side
    logic [KW-1:0]  r_qlen, n_qlen;
    logic           r_qovf, n_qovf;
    logic           r_qzero, n_qzero;
    logic           r_qclosed, n_qclosed;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic           r_byp_valid;
    logic [AW-1:0]  r_byp_addr;
    logic [7:0]     r_byp_data;
    logic [7:0]     ram_q;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  kp_idx;
    logic [7:0]     qbyte;

    // document side
    t_phase         r_phase, n_phase;
    logic [PW-1:0]  r_pos, n_pos;
    logic [PW-1:0]  r_doc_len, n_doc_len;
    logic [31:0]    r_gather, n_gather;
    logic [1:0]     r_lcnt, n_lcnt;
    logic [31:0]    r_vrem, n_vrem;
    logic [KPW-1:0] r_kp, n_kp;
    logic           r_kmatch, n_kmatch;
    logic [7:0]     r_ctype, n_ctype;
    logic [PW-1:0]  r_estart, n_estart;
    logic           r_result_sent, n_result_sent;
    logic           r_eoo, n_eoo;
    logic           r_hit, n_hit;
    logic           r_pend, n_pend;
    logic [7:0]     r_pend_type, n_pend_type;
    logic [PW-1:0]  r_pend_start, n_pend_start;
    logic [PW-1:0]  r_pend_len, n_pend_len;

    // result register
    logic           r_out_valid;
    t_status        r_out_status;
    logic [7:0]     r_out_type;
    logic [7:0]     r_out_offset;
    logic [8:0]     r_out_length;

    logic           in_fire;
    logic           emit;
    t_status        e_st;
    logic [7:0]     e_ty;
    logic [PW-1:0]  e_off;
    logic [PW-1:0]  e_len;

    assign o_ready = !r_out_valid || i_ready;
    assign in_fire = i_valid && o_ready;

    bfl_ram #(
        .WIDTH (8),
        .DEPTH (KEY_MAX)
    ) u_qram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_data_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_q)
    );

    // read ahead at the key position of the next cycle
    assign rd_addr = (n_kp < KPW'(KEY_MAX)) ? n_kp[AW-1:0] : '0;
    assign kp_idx  = (r_kp < KPW'(KEY_MAX)) ? r_kp[AW-1:0] : '0;
    assign qbyte   = (r_byp_valid && r_byp_addr == kp_idx) ? r_byp_data : ram_q;

    always_comb begin
        logic [KW-1:0] eff_len;
        logic          eff_zero;
        logic          eff_ovf;
        logic [31:0]   gather_new;
        logic          stop;
        t_status       stop_st;
        logic          khit;
        logic          kmatch_byte;
        logic [PW-1:0] elen;

        n_qlen        = r_qlen;
        n_qovf        = r_qovf;
        n_qzero       = r_qzero;
        n_qclosed     = r_qclosed;
        wr_en         = 1'b0;
        wr_addr       = '0;

        n_phase       = r_phase;
        n_pos         = r_pos;
        n_doc_len     = r_doc_len;
        n_gather      = r_gather;
        n_lcnt        = r_lcnt;
        n_vrem        = r_vrem;
        n_kp          = r_kp;
        n_kmatch      = r_kmatch;
        n_ctype       = r_ctype;
        n_estart      = r_estart;
        n_result_sent = r_result_sent;
        n_eoo         = r_eoo;
        n_hit         = r_hit;
        n_pend        = r_pend;
        n_pend_type   = r_pend_type;
        n_pend_start  = r_pend_start;
        n_pend_len    = r_pend_len;

        emit    = 1'b0;
        e_st    = ST_FOUND;
        e_ty    = '0;
        e_off   = '0;
        e_len   = '0;
        stop    = 1'b0;
        stop_st = ST_END;

        eff_len  = r_qclosed ? '0 : r_qlen;
        eff_zero = r_qclosed ? 1'b0 : r_qzero;
        eff_ovf  = r_qclosed ? 1'b0 : r_qovf;

        gather_new  = '0;
        elen        = r_pos - r_estart + PW'(1);
        khit        = r_kmatch && !r_qovf && (r_kp == KPW'(r_qlen));
        kmatch_byte = (r_kp < KPW'(r_qlen)) && (r_kp < KPW'(KEY_MAX)) &&
                      (qbyte == i_data_byte);

        if (in_fire && !i_kind) begin
            // query key word; a closed key restarts on its next word
            n_qlen  = eff_len;
            n_qzero = eff_zero;
            n_qovf  = eff_ovf;
            if (!eff_zero) begin
                if (i_data_byte == 8'd0) begin
                    n_qzero = 1'b1;
                end else if (eff_len < KW'(KEY_MAX)) begin
                    wr_en   = 1'b1;
                    wr_addr = eff_len[AW-1:0];
                    n_qlen  = eff_len + KW'(1);
                end else begin
                    n_qovf = 1'b1;
                end
            end
            n_qclosed = i_last;
        end

        if (in_fire && i_kind) begin
            if (r_phase != PH_DONE) begin
                if (r_pos >= PW'(DOC_MAX)) begin
                    stop = 1'b1;
                end else begin
                    unique case (r_phase)
                        PH_HDR: begin
                            gather_new = r_gather |
                                ({24'd0, i_data_byte} << {r_pos[1:0], 3'b000});
                            n_gather = gather_new;
                            if (r_pos >= PW'(3)) begin
                                if (gather_new > 32'(DOC_MAX)) begin
                                    emit = 1'b1;
                                    e_st = ST_OVERSIZE;
                                end else begin
                                    n_doc_len = PW'(gather_new);
                                    n_phase   = PH_TYPE;
                                    n_eoo     = 1'b0;
                                end
                            end
                        end
                        PH_TYPE: begin
                            priority if (r_eoo && i_data_byte == 8'd0) begin
                                stop = 1'b1;
                            end else if (r_pos + PW'(1) >= r_doc_len) begin
                                stop = 1'b1;
                            end else if (i_data_byte > BT_MAX) begin
                                stop    = 1'b1;
                                stop_st = ST_BAD_TYPE;
                            end else begin
                                n_ctype  = i_data_byte;
                                n_estart = r_pos;
                                n_kp     = '0;
                                n_kmatch = 1'b1;
                                n_phase  = PH_KEY;
                            end
                        end
                        PH_KEY: begin
                            if (i_data_byte == 8'd0) begin
                                n_hit = khit;
                                unique case (r_ctype)
                                    BT_STRING: begin
                                        n_pend   = 1'b0;
                                        n_gather = '0;
                                        n_lcnt   = '0;
                                        n_phase  = PH_SLEN;
                                    end
                                    BT_INT32: begin
                                        n_pend  = 1'b0;
                                        n_vrem  = 32'd4;
                                        n_phase = PH_VAL;
                                    end
                                    BT_INT64, BT_DOUBLE: begin
                                        n_pend  = 1'b0;
                                        n_vrem  = 32'd8;
                                        n_phase = PH_VAL;
                                    end
                                    BT_BOOL: begin
                                        n_pend  = 1'b0;
                                        n_vrem  = 32'd1;
                                        n_phase = PH_VAL;
                                    end
                                    default: begin
                                        // value size unknown: hold the match
                                        n_pend = khit;
                                        if (khit) begin
                                            n_pend_type  = r_ctype;
                                            n_pend_start = r_estart;
                                            n_pend_len   = elen;
                                        end
                                        n_phase = PH_TYPE;
                                        n_eoo   = 1'b1;
                                    end
                                endcase
                            end else begin
                                if (!kmatch_byte) begin
                                    n_kmatch = 1'b0;
                                end
                                if (r_kp <= KPW'(KEY_MAX)) begin
                                    n_kp = r_kp + KPW'(1);
                                end
                            end
                        end
                        PH_SLEN: begin
                            gather_new = r_gather |
                                ({24'd0, i_data_byte} << {r_lcnt, 3'b000});
                            n_gather = gather_new;
                            n_lcnt   = r_lcnt + 2'd1;
                            if (r_lcnt == 2'd3) begin
                                n_vrem = gather_new;
                                if (gather_new == 32'd0) begin
                                    if (r_hit) begin
                                        emit  = 1'b1;
                                        e_ty  = r_ctype;
                                        e_off = r_estart;
                                        e_len = elen;
                                    end else begin
                                        n_phase = PH_TYPE;
                                        n_eoo   = 1'b1;
                                    end
                                end else begin
                                    n_phase = PH_VAL;
                                end
                            end
                        end
                        PH_VAL: begin
                            n_vrem = r_vrem - 32'd1;
                            if (r_vrem == 32'd1) begin
                                if (r_hit) begin
                                    emit  = 1'b1;
                                    e_ty  = r_ctype;
                                    e_off = r_estart;
                                    e_len = elen;
                                end else begin
                                    n_phase = PH_TYPE;
                                    n_eoo   = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // a stop reports the held match if there is one
            if (stop) begin
                emit = 1'b1;
                if (r_pend) begin
                    e_st  = ST_FOUND;
                    e_ty  = r_pend_type;
                    e_off = r_pend_start;
                    e_len = r_pend_len;
                end else begin
                    e_st = stop_st;
                end
            end

            if (emit) begin
                n_result_sent = 1'b1;
                n_phase       = PH_DONE;
            end

            if (r_pos < PW'(DOC_MAX)) begin
                n_pos = r_pos + PW'(1);
            end

            if (i_last) begin
                if (!n_result_sent) begin
                    emit = 1'b1;
                    if (n_pend) begin
                        e_st  = ST_FOUND;
                        e_ty  = n_pend_type;
                        e_off = n_pend_start;
                        e_len = n_pend_len;
                    end else begin
                        e_st = ST_END;
                    end
                end
                // back to the header for the next document
                n_phase       = PH_HDR;
                n_pos         = '0;
                n_doc_len     = '0;
                n_gather      = '0;
                n_lcnt        = '0;
                n_vrem        = '0;
                n_kp          = '0;
                n_kmatch      = 1'b1;
                n_ctype       = '0;
                n_estart      = '0;
                n_result_sent = 1'b0;
                n_eoo         = 1'b0;
                n_hit         = 1'b0;
                n_pend        = 1'b0;
                n_pend_type   = '0;
                n_pend_start  = '0;
                n_pend_len    = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen        <= '0;
            r_qovf        <= 1'b0;
            r_qzero       <= 1'b0;
            r_qclosed     <= 1'b0;
            r_byp_valid   <= 1'b0;
            r_phase       <= PH_HDR;
            r_pos         <= '0;
            r_doc_len     <= '0;
            r_gather      <= '0;
            r_lcnt        <= '0;
            r_vrem        <= '0;
            r_kp          <= '0;
            r_kmatch      <= 1'b1;
            r_ctype       <= '0;
            r_estart      <= '0;
            r_result_sent <= 1'b0;
            r_eoo         <= 1'b0;
            r_hit         <= 1'b0;
            r_pend        <= 1'b0;
            r_pend_type   <= '0;
            r_pend_start  <= '0;
            r_pend_len    <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_qlen        <= n_qlen;
            r_qovf        <= n_qovf;
            r_qzero       <= n_qzero;
            r_qclosed     <= n_qclosed;
            r_byp_valid   <= wr_en;
            r_phase       <= n_phase;
            r_pos         <= n_pos;
            r_doc_len     <= n_doc_len;
            r_gather      <= n_gather;
            r_lcnt        <= n_lcnt;
            r_vrem        <= n_vrem;
            r_kp          <= n_kp;
            r_kmatch      <= n_kmatch;
            r_ctype       <= n_ctype;
            r_estart      <= n_estart;
            r_result_sent <= n_result_sent;
            r_eoo         <= n_eoo;
            r_hit         <= n_hit;
            r_pend        <= n_pend;
            r_pend_type   <= n_pend_type;
            r_pend_start  <= n_pend_start;
            r_pend_len    <= n_pend_len;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_byp_addr <= wr_addr;
        r_byp_data <= i_data_byte;
        if (emit) begin
            r_out_status <= e_st;
            r_out_type   <= e_ty;
            r_out_offset <= 8'(e_off);
            r_out_length <= 9'(e_len);
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_element_type   = r_out_type;
    assign o_element_offset = r_out_offset;
    assign o_element_length = r_out_length;

    a_done_means_sent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DONE) |-> r_result_sent)
        else $error("parser done without a result word");

    a_miss_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_FOUND) |->
        (o_element_type == 8'd0 && o_element_offset == 8'd0 &&
         o_element_length == 9'd0))
        else $error("non-found result carries element fields");

    a_last_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_kind && i_last) |=>
        (r_phase == PH_HDR && r_pos == '0 && !r_result_sent))
        else $error("document end did not rewind the parser");

    a_qlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qlen <= KW'(KEY_MAX))
        else $error("query length beyond key store");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= PW'(DOC_MAX))
        else $error("byte position beyond document limit");

endmodule

`default_nettype wire
